>>> hw/rtl/sm3_pkg.sv
`timescale 1ns / 1ps
package sm3_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word_0;
    logic [31:0] digest_word_1;
    logic [31:0] digest_word_2;
    logic [31:0] digest_word_3;
    logic [31:0] digest_word_4;
    logic [31:0] digest_word_5;
    logic [31:0] digest_word_6;
    logic [31:0] digest_word_7;
  } out_item_t;

  typedef logic [7:0][31:0] chain_t;

  localparam chain_t IV = {
    32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
    32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F};

  localparam logic [31:0] T_LO = 32'h79CC4519;
  localparam logic [31:0] T_HI = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  // one 32-bit word handed from the front to the back
  typedef struct packed {
    logic [31:0] word;
    logic        blk_end;   // word 15 of a block: compress after it
    logic        msg_end;   // final block: emit digest and restore IV
  } q_item_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

>>> hw/rtl/sm3_front.sv
`timescale 1ns / 1ps
module sm3_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sm3_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_full,
  output sm3_pkg::q_item_t  q_data
);
  import sm3_pkg::*;

  typedef enum logic [2:0] {
    S_TAKE = 3'b001,
    S_PAD  = 3'b010,
    S_LEN  = 3'b100
  } fstate_t;

  fstate_t     state_r, state_nxt;
  logic [60:0] cnt_r, cnt_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic        lenhi_r, lenhi_nxt;
  logic [63:0] bits;
  logic [2:0]  vb;
  logic [31:0] keep, tailw;

  assign bits = {cnt_r, 3'b000};
  assign vb   = (in_data.valid_bytes > 3'd4) ? 3'd4 : in_data.valid_bytes;

  always_comb begin
    case (vb)
      3'd0:    keep = 32'h0000_0000;
      3'd1:    keep = 32'hFF00_0000;
      3'd2:    keep = 32'hFFFF_0000;
      3'd3:    keep = 32'hFFFF_FF00;
      default: keep = 32'hFFFF_FFFF;
    endcase
    tailw = (in_data.data_word & keep) | ({PAD_BYTE, 24'd0} >> {vb[1:0], 3'b000});
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    lenhi_nxt = lenhi_r;
    q_valid   = 1'b0;
    q_data    = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_TAKE: begin
        in_stall = q_full;
        if (in_valid) begin
          q_valid = 1'b1;
          if (!in_data.last) begin
            q_data = '{word: in_data.data_word, blk_end: (idx_r == 4'd15), msg_end: 1'b0};
            if (!q_full) begin
              cnt_nxt = cnt_r + 61'd4;
              idx_nxt = idx_r + 4'd1;
            end
          end else if (vb == 3'd4) begin
            q_data = '{word: in_data.data_word, blk_end: (idx_r == 4'd15), msg_end: 1'b0};
            if (!q_full) begin
              cnt_nxt   = cnt_r + 61'd4;
              idx_nxt   = idx_r + 4'd1;
              lenhi_nxt = 1'b1;   // pad word 0x80000000 still owed
              state_nxt = S_PAD;
            end
          end else begin
            q_data = '{word: tailw, blk_end: (idx_r == 4'd15), msg_end: 1'b0};
            if (!q_full) begin
              cnt_nxt   = cnt_r + {58'd0, vb};
              idx_nxt   = idx_r + 4'd1;
              lenhi_nxt = 1'b0;
              state_nxt = S_PAD;
            end
          end
        end
      end
      S_PAD: begin
        q_valid = 1'b1;
        q_data  = '{word: lenhi_r ? 32'h8000_0000 : 32'd0,
                    blk_end: (idx_r == 4'd15), msg_end: 1'b0};
        if (!lenhi_r && idx_r == 4'd14) begin
          q_valid = 1'b0;
          state_nxt = S_LEN;
          lenhi_nxt = 1'b1;
        end else if (!q_full) begin
          idx_nxt   = idx_r + 4'd1;
          lenhi_nxt = 1'b0;
        end
      end
      S_LEN: begin
        q_valid = 1'b1;
        q_data  = '{word: lenhi_r ? bits[63:32] : bits[31:0],
                    blk_end: !lenhi_r, msg_end: !lenhi_r};
        if (!q_full) begin
          idx_nxt   = idx_r + 4'd1;
          lenhi_nxt = 1'b0;
          if (!lenhi_r) begin
            state_nxt = S_TAKE;
            cnt_nxt   = '0;
          end
        end
      end
      default: state_nxt = S_TAKE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_TAKE;
      cnt_r   <= '0;
      idx_r   <= '0;
      lenhi_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      lenhi_r <= lenhi_nxt;
    end
  end
endmodule

>>> hw/rtl/sm3_fifo.sv
`timescale 1ns / 1ps
module sm3_fifo #(
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  sm3_pkg::q_item_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             not_empty,
  output sm3_pkg::q_item_t rd_data
);
  import sm3_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  q_item_t         mem_r [Depth];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;

  assign full      = (cnt_r == (AW+1)'(Depth));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en && !full)
        wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      if (rd_en && not_empty)
        rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && not_empty);
    end
  end
endmodule

>>> hw/rtl/sm3_core.sv
`timescale 1ns / 1ps
module sm3_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  sm3_pkg::q_item_t   q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output sm3_pkg::out_item_t out_digest
);
  import sm3_pkg::*;

  typedef enum logic [2:0] {
    C_LOAD  = 3'b001,
    C_ROUND = 3'b010,
    C_FOLD  = 3'b100
  } cstate_t;

  cstate_t       state_r;
  chain_t        cv_r;
  logic [31:0]   w_r [16];     // sliding window W[j..j+15]
  logic [31:0]   a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [5:0]    rnd_r;
  logic          fin_r;
  logic          ov_r;
  out_item_t     od_r;

  logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, wn;
  logic        hi;

  assign hi  = (rnd_r >= 6'd16);
  assign tj  = rotl(hi ? T_HI : T_LO, rnd_r[4:0]);
  assign a12 = rotl(a_r, 5'd12);
  assign ss1 = rotl(a12 + e_r + tj, 5'd7);
  assign ss2 = ss1 ^ a12;
  assign ff  = hi ? ((a_r & b_r) | (a_r & c_r) | (b_r & c_r)) : (a_r ^ b_r ^ c_r);
  assign gg  = hi ? ((e_r & f_r) | (~e_r & g_r)) : (e_r ^ f_r ^ g_r);
  assign tt1 = ff + d_r + ss2 + (w_r[0] ^ w_r[4]);
  assign tt2 = gg + h_r + ss1 + w_r[0];
  assign wn  = p1(w_r[0] ^ w_r[7] ^ rotl(w_r[13], 5'd15)) ^ rotl(w_r[3], 5'd7) ^ w_r[10];

  // a new digest may only be produced into an empty output register
  assign q_pop      = (state_r == C_LOAD) && q_not_empty && !(q_data.msg_end && ov_r);
  assign out_valid  = ov_r;
  assign out_digest = od_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= q_data.word;
      if (q_data.blk_end) begin
        {h_r, g_r, f_r, e_r, d_r, c_r, b_r, a_r} <= cv_r;
      end
    end else if (state_r == C_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
      d_r <= c_r;
      c_r <= rotl(b_r, 5'd9);
      b_r <= a_r;
      a_r <= tt1;
      h_r <= g_r;
      g_r <= rotl(f_r, 5'd19);
      f_r <= e_r;
      e_r <= p0(tt2);
    end
    if (state_r == C_FOLD && fin_r) begin
      od_r <= {cv_r[0] ^ a_r, cv_r[1] ^ b_r, cv_r[2] ^ c_r, cv_r[3] ^ d_r,
               cv_r[4] ^ e_r, cv_r[5] ^ f_r, cv_r[6] ^ g_r, cv_r[7] ^ h_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_LOAD;
      cv_r    <= IV;
      rnd_r   <= '0;
      fin_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      unique case (state_r)
        C_LOAD: begin
          if (q_pop && q_data.blk_end) begin
            state_r <= C_ROUND;
            rnd_r   <= '0;
            fin_r   <= q_data.msg_end;
          end
        end
        C_ROUND: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= C_FOLD;
        end
        C_FOLD: begin
          state_r <= C_LOAD;
          if (fin_r) begin
            cv_r <= IV;
            ov_r <= 1'b1;
          end else begin
            cv_r <= cv_r ^ {h_r, g_r, f_r, e_r, d_r, c_r, b_r, a_r};
          end
        end
        default: state_r <= C_LOAD;
      endcase
    end
  end
endmodule

>>> hw/rtl/sm3_hash_engine.sv
`timescale 1ns / 1ps
// SM3 digest engine. Message words enter big-endian, one item per word; the last item
// carries 0..4 valid bytes and triggers padding, the length field and the digest.
// The front end takes one word per cycle, when the queue is not full, into a
// QueueDepth-entry queue (4 by default); the back end runs one compression round per
// cycle, so a 64-byte block is loaded as 16 words, then compressed in 64 rounds and
// folded into the chaining value or the digest. The final item adds up to 18 padding
// and length words and one or two block compressions before the digest appears on out_digest.
module sm3_hash_engine #(
  parameter int QueueDepth = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sm3_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sm3_pkg::out_item_t out_digest
);
  import sm3_pkg::*;

  q_item_t qw_data, qr_data;
  logic    qw_valid, q_full, q_ne, q_pop;

  sm3_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid(qw_valid), .q_full, .q_data(qw_data)
  );

  sm3_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk, .rst_n, .wr_en(qw_valid), .wr_data(qw_data), .full(q_full),
    .rd_en(q_pop), .not_empty(q_ne), .rd_data(qr_data)
  );

  sm3_core u_core (
    .clk, .rst_n, .q_not_empty(q_ne), .q_data(qr_data), .q_pop,
    .out_valid, .out_stall, .out_digest
  );
endmodule

>>> tb/tb_sm3_hash_engine.sv
`timescale 1ns / 1ps
module tb_sm3_hash_engine;
  import sm3_pkg::*;

  localparam int WatchLimit = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_digest;

  sm3_hash_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_digest(out_digest)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // digest predictor state
  logic [31:0] hv[8];
  logic [31:0] blk[16];
  logic [60:0] nbytes;
  out_item_t   digest_q[$];

  int mismatches;
  int digests_seen;
  int items_sent;
  int idle_pct_in;
  int idle_pct_out;
  bit hold_out;
  int quiet;

  function automatic logic [31:0] rl(input logic [31:0] x, input int n);
    logic [63:0] d;
    d = {x, x} << (n % 32);
    return d[63:32];
  endfunction

  task automatic sm3_compress();
    logic [31:0] w[68];
    logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 68; j++) begin
      tt1 = w[j-16] ^ w[j-9] ^ rl(w[j-3], 15);
      w[j] = tt1 ^ rl(tt1, 15) ^ rl(tt1, 23) ^ rl(w[j-13], 7) ^ w[j-6];
    end
    a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
    e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
    for (int j = 0; j < 64; j++) begin
      tj = (j < 16) ? T_LO : T_HI;
      a12 = rl(a, 12);
      ss1 = rl(a12 + e + rl(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rl(b, 9); b = a; a = tt1;
      h = g; g = rl(f, 19); f = e;
      e = tt2 ^ rl(tt2, 9) ^ rl(tt2, 17);
    end
    hv[0] ^= a; hv[1] ^= b; hv[2] ^= c; hv[3] ^= d;
    hv[4] ^= e; hv[5] ^= f; hv[6] ^= g; hv[7] ^= h;
  endtask

  task automatic sm3_restart();
    for (int k = 0; k < 8; k++) hv[k] = IV[k];
    nbytes = '0;
  endtask

  task automatic sm3_absorb(input in_item_t it);
    int idx;
    int vb;
    logic [63:0] bits;
    logic [31:0] keep;
    out_item_t r;
    idx = int'(nbytes[5:2]);
    if (!it.last) begin
      blk[idx] = it.data_word;
      nbytes = nbytes + 61'd4;
      if (idx == 15) sm3_compress();
      return;
    end
    vb = (it.valid_bytes > 3'd4) ? 4 : int'(it.valid_bytes);
    bits = {nbytes + 61'(vb), 3'b000};
    if (vb == 4) begin
      blk[idx] = it.data_word;
      idx++;
      if (idx == 16) begin
        sm3_compress();
        idx = 0;
      end
      blk[idx] = 32'h8000_0000;
    end else begin
      keep = (vb == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * vb));
      blk[idx] = (it.data_word & keep) | ({PAD_BYTE, 24'h0} >> (8 * vb));
    end
    idx++;
    if (idx > 14) begin
      while (idx < 16) blk[idx++] = '0;
      sm3_compress();
      idx = 0;
    end
    while (idx < 14) blk[idx++] = '0;
    blk[14] = bits[63:32];
    blk[15] = bits[31:0];
    sm3_compress();
    r = {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
    digest_q.push_back(r);
    sm3_restart();
  endtask

  // sender: one item, nonblocking at the rising edge; valid stays up for the next item
  task automatic send_item(input in_item_t it);
    while (idle_pct_in > 0 && $urandom_range(99) < idle_pct_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sm3_absorb(it);
    items_sent++;
  endtask

  function automatic in_item_t mk(input logic [31:0] w, input int vb, input bit l);
    in_item_t it;
    it.data_word = w;
    it.valid_bytes = 3'(vb);
    it.last = l;
    return it;
  endfunction

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        digests_seen++;
        if (digest_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected digest %h", out_digest);
        end else begin
          if (out_digest !== digest_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("digest mismatch: exp %h got %h", digest_q[0], out_digest);
          end
          void'(digest_q.pop_front());
        end
      end
      out_stall <= hold_out || (idle_pct_out > 0 && $urandom_range(99) < idle_pct_out);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("watchdog expired");
      $display("tb: failure");
      $finish;
    end
  end

  in_item_t dir_tab[$];

  task automatic rand_msg(input int nwords);
    int vb;
    for (int i = 0; i < nwords; i++)
      send_item(mk($urandom, $urandom_range(7), 1'b0));
    vb = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(4);
    send_item(mk($urandom, vb, 1'b1));
  endtask

  task automatic rand_phase(input int n_items);
    int start;
    int len;
    start = items_sent;
    while (items_sent - start < n_items) begin
      case ($urandom_range(9))
        0: len = 0;
        1, 2: len = 12 + $urandom_range(4);
        3: len = 28 + $urandom_range(5);
        default: len = $urandom_range(40);
      endcase
      rand_msg(len);
    end
  endtask

  initial begin
    out_item_t empty_dig;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_out = 1'b0;
    idle_pct_in = 0;
    idle_pct_out = 0;
    mismatches = 0;
    digests_seen = 0;
    items_sent = 0;
    sm3_restart();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message right after reset: known digest
    empty_dig = {32'h1ab21d83, 32'h55cfa17f, 32'h8e611948, 32'h31e81a8f,
                 32'h22bec8c7, 32'h28fefb74, 32'h7ed035eb, 32'h5082aa2b};
    send_item(mk(32'hDEAD_BEEF, 0, 1'b1));
    if (digest_q.size() == 0 || digest_q[$] !== empty_dig) begin
      mismatches++;
      $display("predictor empty digest wrong");
    end
    // "abc"
    dir_tab.push_back(mk(32'h6162_63FF, 3, 1'b1));
    dir_tab.push_back(mk(32'hFFFF_FFFF, 4, 1'b1));
    dir_tab.push_back(mk(32'h0000_0000, 4, 1'b1));
    dir_tab.push_back(mk(32'hFFFF_FFFF, 1, 1'b1));
    dir_tab.push_back(mk(32'hFFFF_FFFF, 2, 1'b1));
    dir_tab.push_back(mk(32'hA5A5_A5A5, 5, 1'b1));
    dir_tab.push_back(mk(32'h5A5A_5A5A, 6, 1'b1));
    dir_tab.push_back(mk(32'h1234_5678, 7, 1'b1));
    for (int i = 0; i < 13; i++) dir_tab.push_back(mk(32'hFFFF_FFFF, 7, 1'b0));
    dir_tab.push_back(mk(32'h0000_0000, 4, 1'b1));
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    // 13..16 full words plus a final item cross the length boundary
    for (int n = 13; n <= 16; n++) rand_msg(n);

    // long receiver hold-off while input keeps coming
    hold_out = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_out = 1'b0;
      end
      begin
        for (int i = 0; i < 6; i++) rand_msg(3);
        in_valid <= 1'b0;
      end
    join
    @(posedge clk);

    idle_pct_in = 14;
    idle_pct_out = 63;
    rand_phase(620);
    idle_pct_in = 63;
    idle_pct_out = 14;
    rand_phase(620);
    idle_pct_in = 0;
    idle_pct_out = 0;
    rand_phase(620);
    in_valid <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d items, checked %0d digests, %0d mismatches",
             items_sent, digests_seen, mismatches);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sm3_pkg.sv
hw/rtl/sm3_front.sv
hw/rtl/sm3_fifo.sv
hw/rtl/sm3_core.sv
hw/rtl/sm3_hash_engine.sv
tb/tb_sm3_hash_engine.sv
